FILE: design/wtg_pkg.sv
// package for the watchdog and thermal governor: item types, constants, ladder table
`timescale 1ns / 1ps

package wtg_pkg;

    localparam int TIME_W        = 32;
    localparam int TEMP_W        = 12;
    localparam int COUNT_W       = 3;
    localparam int LEVEL_W       = 2;
    localparam int FPS_W         = 6;
    localparam int WIDTH_W       = 12;
    localparam int NET_W         = 10;
    localparam int LIMIT_W       = 12;
    localparam int THRESH_W      = 11;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [COUNT_W-1:0] MAX_RESTARTS    = COUNT_W'(5);
    localparam logic [TIME_W-1:0]  GRACE_SEC       = TIME_W'(45);
    localparam logic [TIME_W-1:0]  RESTART_GAP_SEC = TIME_W'(60);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = LEVEL_W'(3);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STALE_LIMIT  = 3'd0,
        CFG_TEMP_HIGH    = 3'd1,
        CFG_TEMP_LOW     = 3'd2,
        CFG_NOMINAL_FPS  = 3'd3,
        CFG_NOMINAL_WID  = 3'd4,
        CFG_NOMINAL_NET  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0]        now_sec;
        logic                     have_real_frame;
        logic [TIME_W-1:0]        real_frame_sec;
        logic signed [TEMP_W-1:0] temperature;
        logic                     restart_accepted;
    } tick_t;

    typedef struct packed {
        logic                  vision_stale;
        logic                  request_restart;
        logic [COUNT_W-1:0]    restart_number;
        logic                  gave_up;
        logic                  recovered;
        logic [LEVEL_W-1:0]    thermal_level;
        logic                  level_changed;
        logic [FPS_W-1:0]      fps_goal;
        logic [WIDTH_W-1:0]    width_goal;
        logic [NET_W-1:0]      target_net_size;
    } result_t;

    typedef struct packed {
        logic [FPS_W-1:0]   fps;
        logic [WIDTH_W-1:0] width;
        logic [NET_W-1:0]   net;
    } rung_t;

    // targets of the throttled levels; level zero comes from configuration
    function automatic rung_t ladder_rung(input logic [LEVEL_W-1:0] lvl);
        rung_t r;
        case (lvl)
            2'd1:    r = '{fps: FPS_W'(5), width: WIDTH_W'(480), net: NET_W'(256)};
            2'd2:    r = '{fps: FPS_W'(3), width: WIDTH_W'(320), net: NET_W'(224)};
            2'd3:    r = '{fps: FPS_W'(2), width: WIDTH_W'(320), net: NET_W'(192)};
            default: r = '{fps: FPS_W'(10), width: WIDTH_W'(640), net: NET_W'(300)};
        endcase
        return r;
    endfunction

endpackage

FILE: design/watchdog_thermal_governor_core.sv
// top level of the watchdog and thermal governor: staleness, restart policy, thermal ladder
`timescale 1ns / 1ps

// One supervisor tick in, one result item out. The whole tick is evaluated in the
// accept cycle by a few 32-bit compares and one saturating add, and the result is
// registered, so a tick is taken every cycle while tick_stall is low.
// A two-entry output register (result plus skid) lets a tick be taken while a result
// waits; tick_stall rises only when both entries are full. Configuration writes take
// effect at the next tick and are meant for idle periods.
module watchdog_thermal_governor_core
    import wtg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   tick_valid,
    output logic                   tick_stall,
    input  tick_t                  tick,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    logic [LIMIT_W-1:0]  stale_limit_reg;
    logic [THRESH_W-1:0] temp_high_reg;
    logic [THRESH_W-1:0] temp_low_reg;
    logic [FPS_W-1:0]    nominal_fps_reg;
    logic [WIDTH_W-1:0]  nominal_width_reg;
    logic [NET_W-1:0]    nominal_net_reg;

    logic [TIME_W-1:0]  grace_deadline_reg, grace_deadline_next;
    logic [TIME_W-1:0]  last_restart_reg, last_restart_next;
    logic [COUNT_W-1:0] restart_count_reg, restart_count_next;
    logic               prior_stale_reg, prior_stale_next;
    logic               stale_flag_reg, stale_flag_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    result_t result_next;

    logic              accept;
    logic              past_grace;
    logic              stale;
    logic              gap_ok;
    logic [TIME_W:0]   deadline_sum;
    logic [TIME_W-1:0] deadline_sat;
    logic [TIME_W-1:0] frame_age;
    logic [TIME_W-1:0] restart_age;
    logic              temp_valid;
    logic [THRESH_W-1:0] temp_mag;
    rung_t             rung;

    assign accept     = tick_valid && !tick_stall;
    assign tick_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_limit_reg   <= LIMIT_W'(30);
            temp_high_reg     <= THRESH_W'(750);
            temp_low_reg      <= THRESH_W'(650);
            nominal_fps_reg   <= FPS_W'(10);
            nominal_width_reg <= WIDTH_W'(640);
            nominal_net_reg   <= NET_W'(300);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STALE_LIMIT: stale_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_TEMP_HIGH:   temp_high_reg     <= cfg_data[THRESH_W-1:0];
                CFG_TEMP_LOW:    temp_low_reg      <= cfg_data[THRESH_W-1:0];
                CFG_NOMINAL_FPS: nominal_fps_reg   <= cfg_data[FPS_W-1:0];
                CFG_NOMINAL_WID: nominal_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_NOMINAL_NET: nominal_net_reg   <= cfg_data[NET_W-1:0];
                default: ;
            endcase
        end
    end

    // staleness and restart policy
    always_comb
    begin
        frame_age    = tick.now_sec - tick.real_frame_sec;
        restart_age  = tick.now_sec - last_restart_reg;
        deadline_sum = {1'b0, tick.now_sec} + {1'b0, GRACE_SEC};
        deadline_sat = deadline_sum[TIME_W] ? '1 : deadline_sum[TIME_W-1:0];
        past_grace   = tick.now_sec > grace_deadline_reg;
        gap_ok       = (tick.now_sec > last_restart_reg) && (restart_age > RESTART_GAP_SEC);

        if (tick.have_real_frame)
        begin
            stale = (tick.now_sec > tick.real_frame_sec) &&
                    (frame_age > {{(TIME_W-LIMIT_W){1'b0}}, stale_limit_reg});
        end
        else
        begin
            stale = past_grace;
        end

        grace_deadline_next = grace_deadline_reg;
        last_restart_next   = last_restart_reg;
        restart_count_next  = restart_count_reg;
        prior_stale_next    = prior_stale_reg;
        stale_flag_next     = stale_flag_reg;
        result_next         = '0;

        if (stale && past_grace)
        begin
            stale_flag_next  = 1'b1;
            prior_stale_next = 1'b1;
            if (gap_ok && (restart_count_reg < MAX_RESTARTS))
            begin
                result_next.request_restart = 1'b1;
                if (tick.restart_accepted)
                begin
                    restart_count_next = restart_count_reg + COUNT_W'(1);
                end
                last_restart_next   = tick.now_sec;
                grace_deadline_next = deadline_sat;
            end
            else if (restart_count_reg >= MAX_RESTARTS)
            begin
                result_next.gave_up = 1'b1;
            end
        end
        else if (!stale)
        begin
            result_next.recovered = prior_stale_reg;
            stale_flag_next       = 1'b0;
            restart_count_next    = '0;
            prior_stale_next      = 1'b0;
        end

        // thermal ladder, at most one level per tick
        temp_valid = !tick.temperature[TEMP_W-1] && (tick.temperature != '0);
        temp_mag   = tick.temperature[THRESH_W-1:0];
        level_next = level_reg;
        if (temp_valid)
        begin
            if ((temp_mag >= temp_high_reg) && (level_reg < LEVEL_MAX))
            begin
                level_next = level_reg + LEVEL_W'(1);
            end
            else if ((temp_mag <= temp_low_reg) && (level_reg != '0))
            begin
                level_next = level_reg - LEVEL_W'(1);
            end
        end

        rung = ladder_rung(level_next);
        if (level_next == '0)
        begin
            rung.fps   = nominal_fps_reg;
            rung.width = nominal_width_reg;
            rung.net   = nominal_net_reg;
        end

        result_next.vision_stale    = stale_flag_next;
        result_next.restart_number  = restart_count_next;
        result_next.thermal_level   = level_next;
        result_next.level_changed   = level_next != level_reg;
        result_next.fps_goal        = rung.fps;
        result_next.width_goal      = rung.width;
        result_next.target_net_size = rung.net;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_deadline_reg <= GRACE_SEC;
            last_restart_reg   <= '0;
            restart_count_reg  <= '0;
            prior_stale_reg    <= 1'b0;
            stale_flag_reg     <= 1'b0;
            level_reg          <= '0;
        end
        else if (accept)
        begin
            grace_deadline_reg <= grace_deadline_next;
            last_restart_reg   <= last_restart_next;
            restart_count_reg  <= restart_count_next;
            prior_stale_reg    <= prior_stale_next;
            stale_flag_reg     <= stale_flag_next;
            level_reg          <= level_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result_stall)
            begin
                if (accept)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && result_stall)
        begin
            if (accept)
            begin
                skid_data_reg <= result_next;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while result register empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        restart_count_reg <= MAX_RESTARTS)
        else $error("restart count beyond limit");

    a_request_while_stale: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.request_restart) |-> result.vision_stale)
        else $error("restart requested without stale flag");

    a_gave_up_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.gave_up) |-> (result.restart_number == MAX_RESTARTS))
        else $error("gave up below restart limit");

    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (level_next != level_reg)) |=>
            ((level_reg == $past(level_reg) + LEVEL_W'(1)) ||
             (level_reg == $past(level_reg) - LEVEL_W'(1))))
        else $error("thermal level moved by more than one");
`endif

endmodule

FILE: dv/tb.sv
// testbench for the watchdog and thermal governor: directed and random ticks checked against a local model
`timescale 1ns / 1ps

module tb;
    import wtg_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   tick_valid;
    logic                   tick_stall;
    tick_t                  tick;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;

    watchdog_thermal_governor_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // local copy of the configuration
    logic [LIMIT_W-1:0]  lim_cfg = LIMIT_W'(30);
    logic [THRESH_W-1:0] thi_cfg = THRESH_W'(750);
    logic [THRESH_W-1:0] tlo_cfg = THRESH_W'(650);
    logic [FPS_W-1:0]    fps_cfg = FPS_W'(10);
    logic [WIDTH_W-1:0]  wid_cfg = WIDTH_W'(640);
    logic [NET_W-1:0]    net_cfg = NET_W'(300);

    // local copy of the governor state
    logic [TIME_W-1:0]  grace_end   = GRACE_SEC;
    logic [TIME_W-1:0]  last_kick   = '0;
    logic [COUNT_W-1:0] kick_count  = '0;
    logic               had_stale   = 1'b0;
    logic               stale_now   = 1'b0;
    logic [LEVEL_W-1:0] lvl         = '0;

    result_t due_results[$];
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;

    // stimulus time line and episode shaping
    logic [TIME_W-1:0] clock_sec    = '0;
    logic [TIME_W-1:0] frame_sec    = '0;
    int                episode_kind = 0;
    int                episode_left = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL watchdog_thermal_governor_core");
        $finish;
    end

    function automatic result_t govern_tick(input tick_t t);
        result_t            r;
        logic               stale;
        logic               past_grace;
        logic               gap_ok;
        logic [TIME_W:0]    deadline;
        logic [LEVEL_W-1:0] next_lvl;
        r = '0;
        past_grace = t.now_sec > grace_end;
        if (t.have_real_frame)
            stale = (t.now_sec > t.real_frame_sec) &&
                    ((t.now_sec - t.real_frame_sec) > TIME_W'(lim_cfg));
        else
            stale = past_grace;
        if (stale && past_grace) begin
            gap_ok = (t.now_sec > last_kick) && ((t.now_sec - last_kick) > RESTART_GAP_SEC);
            stale_now = 1'b1;
            if (gap_ok && kick_count < MAX_RESTARTS) begin
                r.request_restart = 1'b1;
                if (t.restart_accepted)
                    kick_count = kick_count + 1'b1;
                last_kick = t.now_sec;
                deadline = {1'b0, t.now_sec} + {1'b0, GRACE_SEC};
                grace_end = deadline[TIME_W] ? '1 : deadline[TIME_W-1:0];
            end
            else if (kick_count >= MAX_RESTARTS) begin
                r.gave_up = 1'b1;
            end
            had_stale = 1'b1;
        end
        else if (!stale) begin
            r.recovered = had_stale;
            stale_now = 1'b0;
            kick_count = '0;
            had_stale = 1'b0;
        end
        if ($signed(t.temperature) > 0) begin
            next_lvl = lvl;
            if (t.temperature[THRESH_W-1:0] >= thi_cfg && lvl < LEVEL_MAX)
                next_lvl = lvl + 1'b1;
            else if (t.temperature[THRESH_W-1:0] <= tlo_cfg && lvl > 0)
                next_lvl = lvl - 1'b1;
            r.level_changed = next_lvl != lvl;
            lvl = next_lvl;
        end
        r.vision_stale   = stale_now;
        r.restart_number = kick_count;
        r.thermal_level  = lvl;
        case (lvl)
            2'd0:
            begin
                r.fps_goal = fps_cfg;
                r.width_goal = wid_cfg;
                r.target_net_size = net_cfg;
            end
            2'd1:
            begin
                r.fps_goal = FPS_W'(5);
                r.width_goal = WIDTH_W'(480);
                r.target_net_size = NET_W'(256);
            end
            2'd2:
            begin
                r.fps_goal = FPS_W'(3);
                r.width_goal = WIDTH_W'(320);
                r.target_net_size = NET_W'(224);
            end
            default:
            begin
                r.fps_goal = FPS_W'(2);
                r.width_goal = WIDTH_W'(320);
                r.target_net_size = NET_W'(192);
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (due_results.size() == 0) begin
            note_mismatch($sformatf("result item with none due: %h", got));
            return;
        end
        want = due_results.pop_front();
        if (got.vision_stale !== want.vision_stale)
            note_mismatch($sformatf("vision_stale %0d want %0d",
                got.vision_stale, want.vision_stale));
        if (got.request_restart !== want.request_restart)
            note_mismatch($sformatf("request_restart %0d want %0d",
                got.request_restart, want.request_restart));
        if (got.restart_number !== want.restart_number)
            note_mismatch($sformatf("restart_number %0d want %0d",
                got.restart_number, want.restart_number));
        if (got.gave_up !== want.gave_up)
            note_mismatch($sformatf("gave_up %0d want %0d", got.gave_up, want.gave_up));
        if (got.recovered !== want.recovered)
            note_mismatch($sformatf("recovered %0d want %0d", got.recovered, want.recovered));
        if (got.thermal_level !== want.thermal_level)
            note_mismatch($sformatf("thermal_level %0d want %0d",
                got.thermal_level, want.thermal_level));
        if (got.level_changed !== want.level_changed)
            note_mismatch($sformatf("level_changed %0d want %0d",
                got.level_changed, want.level_changed));
        if (got.fps_goal !== want.fps_goal)
            note_mismatch($sformatf("fps_goal %0d want %0d", got.fps_goal, want.fps_goal));
        if (got.width_goal !== want.width_goal)
            note_mismatch($sformatf("width_goal %0d want %0d",
                got.width_goal, want.width_goal));
        if (got.target_net_size !== want.target_net_size)
            note_mismatch($sformatf("target_net_size %0d want %0d",
                got.target_net_size, want.target_net_size));
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
    end

    always @(posedge clk) begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        due_results.push_back(govern_tick(t));
    endtask

    task automatic wait_idle;
        tick_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_STALE_LIMIT: lim_cfg = data[LIMIT_W-1:0];
            CFG_TEMP_HIGH:   thi_cfg = data[THRESH_W-1:0];
            CFG_TEMP_LOW:    tlo_cfg = data[THRESH_W-1:0];
            CFG_NOMINAL_FPS: fps_cfg = data[FPS_W-1:0];
            CFG_NOMINAL_WID: wid_cfg = data[WIDTH_W-1:0];
            CFG_NOMINAL_NET: net_cfg = data[NET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] thi,
                             input logic [CFG_DATA_W-1:0] tlo, input logic [CFG_DATA_W-1:0] fps,
                             input logic [CFG_DATA_W-1:0] wid, input logic [CFG_DATA_W-1:0] net);
        wait_idle();
        write_reg(CFG_STALE_LIMIT, lim);
        write_reg(CFG_TEMP_HIGH, thi);
        write_reg(CFG_TEMP_LOW, tlo);
        write_reg(CFG_NOMINAL_FPS, fps);
        write_reg(CFG_NOMINAL_WID, wid);
        write_reg(CFG_NOMINAL_NET, net);
        cfg_we <= 1'b0;
    endtask

    function automatic tick_t make_tick(input logic [TIME_W-1:0] now, input logic have,
                                        input logic [TIME_W-1:0] fts, input int temp,
                                        input logic acc);
        tick_t t;
        t.now_sec = now;
        t.have_real_frame = have;
        t.real_frame_sec = fts;
        t.temperature = TEMP_W'(temp);
        t.restart_accepted = acc;
        return t;
    endfunction

    // mostly near the thresholds so the ladder moves both ways
    function automatic int pick_temp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return int'(thi_cfg) + int'($urandom_range(30)) - 15;
        if (sel < 70)
            return int'(tlo_cfg) + int'($urandom_range(30)) - 15;
        if (sel < 90)
            return int'($urandom_range(1650)) - 400;
        return -int'($urandom_range(400));
    endfunction

    // episodes of fresh frames, a frozen frame, no frame, or mixed ages, plus some noise
    function automatic tick_t random_tick();
        tick_t             t;
        logic [TIME_W-1:0] age;
        if (episode_left == 0) begin
            episode_kind = $urandom_range(3);
            episode_left = $urandom_range(4, 30);
            if (clock_sec > lim_cfg + 5)
                frame_sec = clock_sec - lim_cfg - $urandom_range(1, 5);
            else
                frame_sec = '0;
        end
        episode_left--;
        if ($urandom_range(99) < 8) begin
            if ($urandom_range(1) && clock_sec > 200) begin
                t.now_sec = clock_sec - $urandom_range(200);
            end
            else begin
                clock_sec = clock_sec + $urandom_range(5000);
                t.now_sec = clock_sec;
            end
            t.have_real_frame = 1'($urandom_range(1));
            t.real_frame_sec = $urandom;
            t.temperature = TEMP_W'($urandom);
            t.restart_accepted = 1'($urandom_range(1));
            return t;
        end
        if (episode_kind == 1)
            clock_sec = clock_sec + $urandom_range(20, 75);
        else
            clock_sec = clock_sec + $urandom_range(25);
        t.now_sec = clock_sec;
        t.have_real_frame = 1'b1;
        case (episode_kind)
            0:
            begin
                age = $urandom_range(lim_cfg);
                t.real_frame_sec = (clock_sec > age) ? clock_sec - age : '0;
            end
            1:
            begin
                t.real_frame_sec = frame_sec;
            end
            2:
            begin
                t.have_real_frame = 1'b0;
                t.real_frame_sec = $urandom;
            end
            default:
            begin
                if ($urandom_range(99) < 15) begin
                    t.real_frame_sec = clock_sec + $urandom_range(1, 100);
                end
                else begin
                    age = $urandom_range(2 * lim_cfg + 2);
                    t.real_frame_sec = (clock_sec > age) ? clock_sec - age : '0;
                end
            end
        endcase
        t.temperature = TEMP_W'(pick_temp());
        t.restart_accepted = $urandom_range(99) < 85;
        return t;
    endfunction

    task automatic run_ticks(input int n);
        repeat (n) send_tick(random_tick());
    endtask

    task automatic test_directed;
        int k;
        send_idle_pct = 0;
        stall_pct = 0;
        // inside the startup grace, first with an invalid temperature
        send_tick(make_tick(0, 1'b0, '0, 0, 1'b1));
        send_tick(make_tick(30, 1'b0, '1, 1250, 1'b1));
        // no frame yet and past grace, but too soon for a restart
        send_tick(make_tick(46, 1'b0, '0, 1250, 1'b1));
        // refused restart
        send_tick(make_tick(61, 1'b0, '0, 1250, 1'b0));
        // fresh frame, recovery, ladder held at the top
        send_tick(make_tick(70, 1'b1, 65, 1250, 1'b1));
        // frame in the future
        send_tick(make_tick(80, 1'b1, 90, 700, 1'b1));
        // stale inside grace, low threshold met exactly
        send_tick(make_tick(100, 1'b1, 10, 650, 1'b1));
        send_tick(make_tick(107, 1'b1, 10, -400, 1'b1));
        send_tick(make_tick(122, 1'b1, 10, 1, 1'b1));
        // time going backwards
        send_tick(make_tick(100, 1'b1, 10, 651, 1'b1));
        // restarts until the limit, then gave up
        for (k = 0; k < 8; k++)
            send_tick(make_tick(200 + 61 * k, 1'b0, '0, 749 + (k % 2), 1'b1));
        send_tick(make_tick(900, 1'b1, 900, 1250, 1'b1));
        send_tick(make_tick(905, 1'b1, 0, 1249, 1'b1));
        clock_sec = 1000;
    endtask

    task automatic test_settings;
        send_idle_pct = 35;
        stall_pct = 35;
        // both thresholds met at once, age limit of one, largest width and net targets
        configure(1, 0, 1250, 60, 4095, 1023);
        run_ticks(100);
        configure(3600, 1250, 0, 1, 1, 1);
        run_ticks(100);
        // high bits beyond the threshold, fps and net register widths, zero targets
        configure(12'hFFF, 12'hFFF, 12'h800, 12'hFC0, 12'h000, 12'hC00);
        run_ticks(100);
        configure(CFG_DATA_W'($urandom_range(1, 3600)), CFG_DATA_W'($urandom_range(1250)),
                  CFG_DATA_W'($urandom_range(1250)), CFG_DATA_W'($urandom_range(1, 60)),
                  CFG_DATA_W'($urandom_range(1, 4095)), CFG_DATA_W'($urandom_range(1, 1023)));
        run_ticks(100);
        configure(30, 750, 650, 10, 640, 300);
        run_ticks(100);
    endtask

    task automatic test_idling;
        send_idle_pct = 0;
        stall_pct = 0;
        run_ticks(180);
        send_idle_pct = 74;
        run_ticks(180);
        send_idle_pct = 0;
        stall_pct = 74;
        run_ticks(180);
        send_idle_pct = 35;
        stall_pct = 35;
        run_ticks(180);
    endtask

    task automatic test_drain_pause;
        send_idle_pct = 0;
        stall_pct = 50;
        run_ticks(50);
        wait_idle();
        run_ticks(50);
    endtask

    task automatic test_time_wrap;
        send_idle_pct = 0;
        stall_pct = 0;
        // grace deadline saturates at the top of the time range
        send_tick(make_tick(32'hFFFF_FFF0, 1'b0, '0, 1250, 1'b1));
        send_tick(make_tick(32'hFFFF_FFFF, 1'b1, '0, 1249, 1'b1));
        send_tick(make_tick(32'hFFFF_FFFF, 1'b0, '1, -1, 1'b0));
        clock_sec = 32'hFFFF_FF00;
        send_idle_pct = 35;
        stall_pct = 35;
        run_ticks(20);
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_STALE_LIMIT;
        cfg_data = '0;
        tick_valid = 1'b0;
        tick = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_idling();
        test_drain_pause();
        test_time_wrap();
        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("PASS watchdog_thermal_governor_core");
        else
            $display("FAIL watchdog_thermal_governor_core");
        $finish;
    end

endmodule
